/* rtl/pvec_pkg.sv */
// ----------------------------------------------------------------------------
// pvec_pkg
// Shared sizes, codes and types of the polygon vertex/edge contact block.
// ----------------------------------------------------------------------------
package pvec_pkg;

	// store depths
	localparam int MAX_NODES_A = 8;
	localparam int MAX_NODES_B = 8;

	// store address and fill count widths
	localparam int AW_A    = (MAX_NODES_A > 1) ? $clog2(MAX_NODES_A) : 1;
	localparam int AW_B    = (MAX_NODES_B > 1) ? $clog2(MAX_NODES_B) : 1;
	localparam int CNT_A_W = $clog2(MAX_NODES_A + 1);
	localparam int CNT_B_W = $clog2(MAX_NODES_B + 1);

	// datapath widths
	localparam int COORD_W   = 16;
	localparam int POS_W     = COORD_W + 1;
	localparam int DIFF_W    = POS_W + 1;
	localparam int PROD_W    = 2 * DIFF_W;
	localparam int CROSS_W   = PROD_W + 1;
	localparam int TOL_W     = 8;
	localparam int IDX_OUT_W = 3;

	localparam logic [TOL_W-1:0] TOL_RESET = 8'd2;

	// item selector carried in tuser
	typedef enum logic [1:0] {
		FUNC_CLEAR    = 2'd0,
		FUNC_APPEND_A = 2'd1,
		FUNC_APPEND_B = 2'd2,
		FUNC_RUN      = 2'd3
	} func_t;

	// one stored node offset
	typedef struct packed {
		logic signed [COORD_W-1:0] dy;
		logic signed [COORD_W-1:0] dx;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	// operations of the shared arithmetic unit
	typedef enum logic [2:0] {
		OP_NONE,
		OP_START,
		OP_LOAD_A0,
		OP_LOAD_A1,
		OP_LOAD_P,
		OP_MUL1,
		OP_MUL2
	} op_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_A0,
		ST_RD_A1,
		ST_LD_A1,
		ST_RD_B,
		ST_LD_B,
		ST_MUL1,
		ST_MUL2,
		ST_CMP,
		ST_EMIT,
		ST_DONE
	} state_t;

endpackage

/* rtl/polygon_vertex_edge_contact_core.sv */
// ----------------------------------------------------------------------------
// polygon_vertex_edge_contact_core
// Vertex-on-edge contact check between two polygon bodies.
// ----------------------------------------------------------------------------
// Clear and append items each take effect as they are taken, and the block is
// ready again on the next cycle. A run item walks every body A edge (node e to
// node e+1) against every body B node through one shared 18x18 multiplier:
// it fetches each edge from the A store, then for every edge/node pair it
// fetches the node, adds, does two multiplies and compares, and gives a hit
// result for every hit. The run ends with the done result, which is all that
// a run with fewer than two A nodes gives. Hit and done results are held while
// m_tready is low.
// The input is not ready during a run. Results carry hit in m_tuser and the
// edge and node indices in m_tdata; the done result has m_tlast set. Store
// entries are only read below the fill counts, so the stores need no clearing.
// ----------------------------------------------------------------------------
module polygon_vertex_edge_contact_core
	import pvec_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// node_dx, node_dy, pos_ax, pos_ay, pos_bx, pos_by
	input  logic [95:0]      s_tdata,
	// func
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	// edge_index, node_index, zero fill
	output logic [7:0]       m_tdata,
	// hit
	output logic [0:0]       m_tuser,
	output logic             m_tlast,
	input  logic             tolerance_we,
	input  logic [TOL_W-1:0] tolerance_wdata
);

	logic [TOL_W-1:0]     tolerance_q;
	logic                 we_a, we_b;
	logic [AW_A-1:0]      waddr_a, raddr_a;
	logic [AW_B-1:0]      waddr_b, raddr_b;
	logic [NODE_W-1:0]    rdata_a, rdata_b;
	node_t                wnode;
	op_t                  op;
	logic                 hit;
	logic                 out_hit;
	logic [IDX_OUT_W-1:0] out_edge, out_node;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOL_RESET;
		end else if (tolerance_we) begin
			tolerance_q <= tolerance_wdata;
		end
	end

	assign wnode.dx = s_tdata[15:0];
	assign wnode.dy = s_tdata[31:16];

	// node stores
	pvec_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES_A)
	) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (waddr_a),
		.wdata (wnode),
		.raddr (raddr_a),
		.rdata (rdata_a)
	);

	pvec_ram #(
		.WIDTH(NODE_W),
		.DEPTH(MAX_NODES_B)
	) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (waddr_b),
		.wdata (wnode),
		.raddr (raddr_b),
		.rdata (rdata_b)
	);

	// sequencer
	pvec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (func_t'(s_tuser)),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.out_hit  (out_hit),
		.out_edge (out_edge),
		.out_node (out_node),
		.out_last (m_tlast),
		.we_a     (we_a),
		.waddr_a  (waddr_a),
		.raddr_a  (raddr_a),
		.we_b     (we_b),
		.waddr_b  (waddr_b),
		.raddr_b  (raddr_b),
		.op       (op),
		.hit      (hit)
	);

	// shared arithmetic unit
	pvec_alu u_alu (
		.clk       (clk),
		.op        (op),
		.pos_ax    (s_tdata[47:32]),
		.pos_ay    (s_tdata[63:48]),
		.pos_bx    (s_tdata[79:64]),
		.pos_by    (s_tdata[95:80]),
		.rd_a      (node_t'(rdata_a)),
		.rd_b      (node_t'(rdata_b)),
		.tolerance (tolerance_q),
		.hit       (hit)
	);

	// result packing
	assign m_tdata = {2'b00, out_node, out_edge};
	assign m_tuser = out_hit;

endmodule

/* rtl/pvec_ram.sv */
// ----------------------------------------------------------------------------
// pvec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvec_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/pvec_alu.sv */
// ----------------------------------------------------------------------------
// pvec_alu
// Shared arithmetic unit: position adds, one signed multiplier reused for
// both cross product terms, and the tolerance window compare.
// ----------------------------------------------------------------------------
module pvec_alu
	import pvec_pkg::*;
(
	input  logic                      clk,
	input  op_t                       op,
	input  logic signed [COORD_W-1:0] pos_ax,
	input  logic signed [COORD_W-1:0] pos_ay,
	input  logic signed [COORD_W-1:0] pos_bx,
	input  logic signed [COORD_W-1:0] pos_by,
	input  node_t                     rd_a,
	input  node_t                     rd_b,
	input  logic [TOL_W-1:0]          tolerance,
	output logic                      hit
);

	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [POS_W-1:0]   a0x_q, a0y_q, a1x_q, a1y_q, px_q, py_q;
	logic signed [PROD_W-1:0]  prod1_q, prod2_q;
	logic signed [DIFF_W-1:0]  opa, opb;
	logic signed [PROD_W-1:0]  mul;
	logic signed [CROSS_W-1:0] xprod;
	logic signed [CROSS_W-1:0] tol_s;

	// operand select for the shared multiplier
	always_comb begin
		case (op)
			OP_MUL1: begin
				opa = DIFF_W'(px_q) - DIFF_W'(a0x_q);
				opb = DIFF_W'(a1y_q) - DIFF_W'(py_q);
			end
			default: begin
				opa = DIFF_W'(a1x_q) - DIFF_W'(px_q);
				opb = DIFF_W'(py_q) - DIFF_W'(a0y_q);
			end
		endcase
	end

	assign mul = opa * opb;

	// operand and product registers
	always_ff @(posedge clk) begin
		case (op)
			OP_START: begin
				ax_q <= pos_ax;
				ay_q <= pos_ay;
				bx_q <= pos_bx;
				by_q <= pos_by;
			end
			OP_LOAD_A0: begin
				a0x_q <= POS_W'(ax_q) + POS_W'(rd_a.dx);
				a0y_q <= POS_W'(ay_q) + POS_W'(rd_a.dy);
			end
			OP_LOAD_A1: begin
				a1x_q <= POS_W'(ax_q) + POS_W'(rd_a.dx);
				a1y_q <= POS_W'(ay_q) + POS_W'(rd_a.dy);
			end
			OP_LOAD_P: begin
				px_q <= POS_W'(bx_q) + POS_W'(rd_b.dx);
				py_q <= POS_W'(by_q) + POS_W'(rd_b.dy);
			end
			OP_MUL1: prod1_q <= mul;
			OP_MUL2: prod2_q <= mul;
			default: ;
		endcase
	end

	// tolerance window on the cross product
	assign xprod = CROSS_W'(prod1_q) - CROSS_W'(prod2_q);
	assign tol_s = signed'({{(CROSS_W - TOL_W){1'b0}}, tolerance});
	assign hit   = (xprod <= tol_s) && (xprod >= -tol_s);

endmodule

/* rtl/pvec_ctrl.sv */
// ----------------------------------------------------------------------------
// pvec_ctrl
// Sequencer: store fill counts, edge and node walk, result hand-off.
// ----------------------------------------------------------------------------
module pvec_ctrl
	import pvec_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  func_t                func,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic                 out_hit,
	output logic [IDX_OUT_W-1:0] out_edge,
	output logic [IDX_OUT_W-1:0] out_node,
	output logic                 out_last,
	output logic                 we_a,
	output logic [AW_A-1:0]      waddr_a,
	output logic [AW_A-1:0]      raddr_a,
	output logic                 we_b,
	output logic [AW_B-1:0]      waddr_b,
	output logic [AW_B-1:0]      raddr_b,
	output op_t                  op,
	input  logic                 hit
);

	state_t               state_q, state_d;
	logic [CNT_A_W-1:0]   count_a_q;
	logic [CNT_B_W-1:0]   count_b_q;
	logic [AW_A-1:0]      e_q;
	logic [AW_B-1:0]      n_q;
	logic                 acc;
	logic                 last_edge, last_node;
	logic                 adv_pair, adv_edge;
	logic [AW_A+IDX_OUT_W-1:0] e_ext;
	logic [AW_B+IDX_OUT_W-1:0] n_ext;

	assign acc       = s_tvalid && s_tready;
	assign last_edge = (CNT_A_W'(e_q) + CNT_A_W'(2)) >= count_a_q;
	assign last_node = (CNT_B_W'(n_q) + CNT_B_W'(1)) >= count_b_q;
	assign adv_pair  = ((state_q == ST_CMP) && !hit) || ((state_q == ST_EMIT) && m_tready);
	assign adv_edge  = ((state_q == ST_LD_A1) && (count_b_q == '0)) || (adv_pair && last_node);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (func == FUNC_RUN)) begin
					state_d = (count_a_q < CNT_A_W'(2)) ? ST_DONE : ST_RD_A0;
				end
			end
			ST_RD_A0: state_d = ST_RD_A1;
			ST_RD_A1: state_d = ST_LD_A1;
			ST_LD_A1: begin
				if (count_b_q != '0) begin
					state_d = ST_RD_B;
				end else begin
					state_d = last_edge ? ST_DONE : ST_RD_A0;
				end
			end
			ST_RD_B:  state_d = ST_LD_B;
			ST_LD_B:  state_d = ST_MUL1;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_CMP;
			ST_CMP, ST_EMIT: begin
				if ((state_q == ST_CMP) && hit) begin
					state_d = ST_EMIT;
				end else if (adv_pair) begin
					if (!last_node) begin
						state_d = ST_RD_B;
					end else begin
						state_d = last_edge ? ST_DONE : ST_RD_A0;
					end
				end
			end
			ST_DONE: begin
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, counts and walk indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_a_q <= '0;
			count_b_q <= '0;
			e_q       <= '0;
			n_q       <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				case (func)
					FUNC_CLEAR: begin
						count_a_q <= '0;
						count_b_q <= '0;
					end
					FUNC_APPEND_A: begin
						if (count_a_q < CNT_A_W'(MAX_NODES_A)) begin
							count_a_q <= count_a_q + CNT_A_W'(1);
						end
					end
					FUNC_APPEND_B: begin
						if (count_b_q < CNT_B_W'(MAX_NODES_B)) begin
							count_b_q <= count_b_q + CNT_B_W'(1);
						end
					end
					default: begin
						e_q <= '0;
						n_q <= '0;
					end
				endcase
			end
			if (adv_edge) begin
				e_q <= e_q + AW_A'(1);
				n_q <= '0;
			end else if (adv_pair) begin
				n_q <= n_q + AW_B'(1);
			end
		end
	end

	assign e_ext = (AW_A + IDX_OUT_W)'(e_q);
	assign n_ext = (AW_B + IDX_OUT_W)'(n_q);

	// outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_EMIT) || (state_q == ST_DONE);
		out_hit  = (state_q == ST_EMIT);
		out_last = (state_q == ST_DONE);
		out_edge = (state_q == ST_EMIT) ? e_ext[IDX_OUT_W-1:0] : '0;
		out_node = (state_q == ST_EMIT) ? n_ext[IDX_OUT_W-1:0] : '0;
		we_a     = acc && (func == FUNC_APPEND_A) && (count_a_q < CNT_A_W'(MAX_NODES_A));
		we_b     = acc && (func == FUNC_APPEND_B) && (count_b_q < CNT_B_W'(MAX_NODES_B));
		waddr_a  = count_a_q[AW_A-1:0];
		waddr_b  = count_b_q[AW_B-1:0];
		raddr_a  = (state_q == ST_RD_A1) ? (e_q + AW_A'(1)) : e_q;
		raddr_b  = n_q;
		case (state_q)
			ST_IDLE:  op = OP_START;
			ST_RD_A1: op = OP_LOAD_A0;
			ST_LD_A1: op = OP_LOAD_A1;
			ST_LD_B:  op = OP_LOAD_P;
			ST_MUL1:  op = OP_MUL1;
			ST_MUL2:  op = OP_MUL2;
			default:  op = OP_NONE;
		endcase
	end

`ifndef SYNTHESIS
	// fill counts stay within the store depths
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_a_q <= CNT_A_W'(MAX_NODES_A)) && (count_b_q <= CNT_B_W'(MAX_NODES_B)))
		else $error("store fill count beyond depth");

	// no new item is taken while a result is offered
	a_ready_vs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// a hit names a real edge and a real node
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |->
		((CNT_A_W'(e_q) + CNT_A_W'(1)) < count_a_q) && (CNT_B_W'(n_q) < count_b_q))
		else $error("hit outside stored nodes");

	// a taken done result returns the block to idle
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && m_tready) |=> (state_q == ST_IDLE))
		else $error("no return to idle after done");
`endif

endmodule
